[src/tbsfr_pkg.sv]
package tbsfr_pkg;

	localparam int DATA_BITS_DEF  = 8;
	localparam int COUNT_BITS_DEF = 16;
	localparam int QUEUE_DEPTH    = 2;
	localparam int SUM_W          = 48;
	localparam int LAT_W          = 32;
	localparam int THR_W          = 32;
	localparam int TICK_W         = 32;
	localparam int DELIM_W        = 8;
	localparam int BYTE_W         = 8;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 32;

	localparam logic [DELIM_W-1:0] DELIM_RESET = 8'h9A;

	typedef enum logic [1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_WINDOW = 2'd1,
		ACT_TICK   = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		STAT_GOOD    = 2'd0,
		STAT_PARITY  = 2'd1,
		STAT_TIMEOUT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_TIMEOUT   = 2'd1,
		REG_DELIMITER = 2'd2,
		REG_PARITY    = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_HUNT,
		ST_DATA,
		ST_PARITY
	} frame_state_t;

	typedef enum logic {
		EV_WINDOW = 1'b0,
		EV_TICK   = 1'b1
	} event_t;

	typedef struct packed {
		logic push;
	} queue_wr_t;

endpackage

[src/tbsfr_front.sv]
module tbsfr_front #(
	parameter int COUNT_BITS = tbsfr_pkg::COUNT_BITS_DEF,
	parameter int EVT_W      = 1 + COUNT_BITS + tbsfr_pkg::SUM_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic [tbsfr_pkg::LAT_W-1:0]   s_tdata,
	input  logic [1:0]                    s_tuser,
	input  logic                          q_ready,
	output tbsfr_pkg::queue_wr_t          q_wr,
	output logic [EVT_W-1:0]              q_data
);

	localparam int SUM_W = tbsfr_pkg::SUM_W;

	logic                  accept;
	tbsfr_pkg::action_t    action;
	tbsfr_pkg::event_t     ev;
	logic [SUM_W:0]        sum_add;
	logic [SUM_W-1:0]      sum_q;
	logic [COUNT_BITS-1:0] count_q;

	always_comb begin
		action    = tbsfr_pkg::action_t'(s_tuser);
		accept    = s_tvalid && q_ready;
		sum_add   = {1'b0, sum_q} + (SUM_W+1)'(s_tdata);
		ev        = (action == tbsfr_pkg::ACT_TICK) ? tbsfr_pkg::EV_TICK : tbsfr_pkg::EV_WINDOW;
		q_wr.push = accept && (action == tbsfr_pkg::ACT_WINDOW || action == tbsfr_pkg::ACT_TICK);
		q_data    = {ev, count_q, sum_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			unique case (action)
				tbsfr_pkg::ACT_SAMPLE: begin
					sum_q <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
					if (count_q != '1)
						count_q <= count_q + 1'b1;
				end
				tbsfr_pkg::ACT_WINDOW: begin
					sum_q   <= '0;
					count_q <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule

[src/tbsfr_queue.sv]
module tbsfr_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = tbsfr_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tbsfr_pkg::queue_wr_t wr,
	input  logic [WIDTH-1:0]     wr_data,
	output logic                 wr_ready,
	input  logic                 rd_pop,
	output logic                 rd_valid,
	output logic [WIDTH-1:0]     rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	always_comb begin
		wr_ready = (count_q != CNT_W'(DEPTH));
		rd_valid = (count_q != '0);
		rd_data  = mem_q[rd_ptr_q];
		do_push  = wr.push && wr_ready;
		do_pop   = rd_pop && rd_valid;
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

[src/tbsfr_back.sv]
module tbsfr_back #(
	parameter int DATA_BITS  = tbsfr_pkg::DATA_BITS_DEF,
	parameter int COUNT_BITS = tbsfr_pkg::COUNT_BITS_DEF,
	parameter int EVT_W      = 1 + COUNT_BITS + tbsfr_pkg::SUM_W
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [tbsfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tbsfr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                               q_valid,
	input  logic [EVT_W-1:0]                   q_data,
	output logic                               q_pop,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [tbsfr_pkg::BYTE_W-1:0]       m_tdata,
	output logic [1:0]                         m_tuser
);

	localparam int SUM_W   = tbsfr_pkg::SUM_W;
	localparam int THR_W   = tbsfr_pkg::THR_W;
	localparam int TICK_W  = tbsfr_pkg::TICK_W;
	localparam int DELIM_W = tbsfr_pkg::DELIM_W;
	localparam int BYTE_W  = tbsfr_pkg::BYTE_W;
	localparam int PROD_W  = THR_W + 1 + COUNT_BITS;
	localparam int CMP_W   = (PROD_W > SUM_W) ? PROD_W : SUM_W;
	localparam int IDX_W   = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;

	logic [THR_W-1:0]        thr_q;
	logic [TICK_W-1:0]       timeout_q;
	logic [DELIM_W-1:0]      delim_q;
	logic                    odd_q;

	tbsfr_pkg::event_t       q_ev;
	logic [COUNT_BITS-1:0]   q_cnt;
	logic [THR_W:0]          thr_inc;
	logic                    en;

	logic                    valid_s1;
	tbsfr_pkg::event_t       ev_s1;
	logic [SUM_W-1:0]        sum_s1;
	logic [PROD_W-1:0]       prod_s1;
	logic                    nz_s1;

	tbsfr_pkg::frame_state_t state_q;
	tbsfr_pkg::frame_state_t state_d;
	logic [DELIM_W-1:0]      hunt_q;
	logic [DELIM_W-1:0]      hunt_next;
	logic [DATA_BITS-1:0]    data_q;
	logic [IDX_W-1:0]        idx_q;
	logic [TICK_W-1:0]       elapsed_q;

	logic                    bit_in;
	logic                    window;
	logic                    tick;
	logic                    match;
	logic                    tmo;
	logic                    last_bit;
	logic                    parity_ok;
	logic                    res_valid;
	tbsfr_pkg::status_t      res_status;
	logic [BYTE_W-1:0]       res_byte;

	logic                    m_valid_q;
	logic [BYTE_W-1:0]       m_byte_q;
	tbsfr_pkg::status_t      m_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= '0;
			timeout_q <= '0;
			delim_q   <= tbsfr_pkg::DELIM_RESET;
			odd_q     <= 1'b0;
		end else if (cfg_valid) begin
			unique case (tbsfr_pkg::reg_index_t'(cfg_index))
				tbsfr_pkg::REG_THRESHOLD: thr_q     <= cfg_data[THR_W-1:0];
				tbsfr_pkg::REG_TIMEOUT:   timeout_q <= cfg_data[TICK_W-1:0];
				tbsfr_pkg::REG_DELIMITER: delim_q   <= cfg_data[DELIM_W-1:0];
				tbsfr_pkg::REG_PARITY:    odd_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		q_ev    = tbsfr_pkg::event_t'(q_data[EVT_W-1]);
		q_cnt   = q_data[SUM_W +: COUNT_BITS];
		thr_inc = {1'b0, thr_q} + (THR_W+1)'(1);
		en      = !m_valid_q || m_tready;
		q_pop   = en && q_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= q_valid;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ev_s1   <= q_ev;
			sum_s1  <= q_data[SUM_W-1:0];
			prod_s1 <= PROD_W'(thr_inc) * PROD_W'(q_cnt);
			nz_s1   <= (q_cnt != '0);
		end
	end

	always_comb begin
		bit_in    = nz_s1 && (CMP_W'(sum_s1) >= CMP_W'(prod_s1));
		window    = valid_s1 && (ev_s1 == tbsfr_pkg::EV_WINDOW);
		tick      = valid_s1 && (ev_s1 == tbsfr_pkg::EV_TICK);
		hunt_next = {hunt_q[DELIM_W-2:0], bit_in};
		match     = (hunt_next == delim_q);
		tmo       = (timeout_q != '0) && (elapsed_q > timeout_q);
		last_bit  = (idx_q == IDX_W'(DATA_BITS-1));
		parity_ok = ((^data_q) ^ bit_in) == odd_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tbsfr_pkg::ST_HUNT:   if (window && match) state_d = tbsfr_pkg::ST_DATA;
			tbsfr_pkg::ST_DATA:   if (window && last_bit) state_d = tbsfr_pkg::ST_PARITY;
			tbsfr_pkg::ST_PARITY: if (window) state_d = tbsfr_pkg::ST_HUNT;
			default:              state_d = tbsfr_pkg::ST_HUNT;
		endcase
	end

	always_comb begin
		res_valid  = 1'b0;
		res_status = tbsfr_pkg::STAT_GOOD;
		res_byte   = '0;
		unique case (state_q)
			tbsfr_pkg::ST_HUNT: begin
				if (window && !match && tmo) begin
					res_valid  = 1'b1;
					res_status = tbsfr_pkg::STAT_TIMEOUT;
				end
			end
			tbsfr_pkg::ST_PARITY: begin
				if (window) begin
					res_valid  = 1'b1;
					res_status = parity_ok ? tbsfr_pkg::STAT_GOOD : tbsfr_pkg::STAT_PARITY;
					res_byte   = BYTE_W'(data_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tbsfr_pkg::ST_HUNT;
			hunt_q    <= '0;
			data_q    <= '0;
			idx_q     <= '0;
			elapsed_q <= '0;
		end else if (en && valid_s1) begin
			state_q <= state_d;
			unique case (state_q)
				tbsfr_pkg::ST_HUNT: begin
					if (tick && elapsed_q != '1)
						elapsed_q <= elapsed_q + 1'b1;
					if (window) begin
						if (match) begin
							hunt_q    <= hunt_next;
							elapsed_q <= '0;
							data_q    <= '0;
							idx_q     <= '0;
						end else if (tmo) begin
							hunt_q    <= '0;
							elapsed_q <= '0;
						end else begin
							hunt_q <= hunt_next;
						end
					end
				end
				tbsfr_pkg::ST_DATA: begin
					if (window) begin
						data_q <= DATA_BITS'({data_q, bit_in});
						idx_q  <= idx_q + 1'b1;
					end
				end
				tbsfr_pkg::ST_PARITY: begin
					if (window) begin
						hunt_q    <= '0;
						elapsed_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (en)
			m_valid_q <= valid_s1 && res_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_status_q <= res_status;
			m_byte_q   <= res_byte;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_byte_q;
	assign m_tuser  = m_status_q;

endmodule

[src/timing_bit_slicer_frame_receiver_core.sv]
// A window end item passes the queue, the stage-1 registers and the output register to m_tvalid.
// Throughput: one item per cycle while s_tready is high; samples are summed in the front end.
// The back end takes one queued window end or tick per cycle while its output register is free.
// A two-entry queue parts the front from the back, so s_tready falls only when the output stalls.
// Reset is asynchronous, active low; it clears control state and loads register reset values.
module timing_bit_slicer_frame_receiver_core #(
	parameter int DATA_BITS  = tbsfr_pkg::DATA_BITS_DEF,
	parameter int COUNT_BITS = tbsfr_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [tbsfr_pkg::LAT_W-1:0]       s_tdata,   // latency
	input  logic [1:0]                        s_tuser,   // action
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [tbsfr_pkg::BYTE_W-1:0]      m_tdata,   // data_byte
	output logic [1:0]                        m_tuser,   // status
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tbsfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tbsfr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int EVT_W = 1 + COUNT_BITS + tbsfr_pkg::SUM_W;

	tbsfr_pkg::queue_wr_t q_wr;
	logic [EVT_W-1:0]     q_wr_data;
	logic                 q_ready;
	logic                 q_pop;
	logic                 q_valid;
	logic [EVT_W-1:0]     q_rd_data;

	assign cfg_ready = 1'b1;
	assign s_tready  = q_ready;

	tbsfr_front #(
		.COUNT_BITS (COUNT_BITS),
		.EVT_W      (EVT_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_ready  (q_ready),
		.q_wr     (q_wr),
		.q_data   (q_wr_data)
	);

	tbsfr_queue #(
		.WIDTH (EVT_W),
		.DEPTH (tbsfr_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wr_data  (q_wr_data),
		.wr_ready (q_ready),
		.rd_pop   (q_pop),
		.rd_valid (q_valid),
		.rd_data  (q_rd_data)
	);

	tbsfr_back #(
		.DATA_BITS  (DATA_BITS),
		.COUNT_BITS (COUNT_BITS),
		.EVT_W      (EVT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_data    (q_rd_data),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

[src/tbsfr_checker.sv]
module tbsfr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [tbsfr_pkg::BYTE_W-1:0]  m_tdata,
	input logic [1:0]                    m_tuser
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == tbsfr_pkg::STAT_TIMEOUT |-> m_tdata == '0)
		else $error("timeout result carries data");

	// queue fills only behind a stalled output
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> $past(m_tvalid && !m_tready))
		else $error("input stalled without output back-pressure");

endmodule

bind timing_bit_slicer_frame_receiver_core tbsfr_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

[sim/timing_bit_slicer_frame_receiver_core_tb.sv]
module timing_bit_slicer_frame_receiver_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int IDLE_LIMIT    = 20000;
	localparam int HOLD_CYCLES   = 600;
	localparam int HOLD_AFTER    = 15;
	localparam int ITEM_TARGET   = 1050;
	localparam int PHASE_ITEMS   = 150;
	localparam int SETTLE_CYCLES = 8;
	localparam int DIR_N         = 21;
	localparam int DIR_SPLIT     = 13;

	typedef struct packed {
		tbsfr_pkg::status_t                status;
		logic [tbsfr_pkg::BYTE_W-1:0]      data;
	} frame_res_t;

	typedef struct packed {
		logic [1:0]                        act;
		logic [tbsfr_pkg::LAT_W-1:0]       lat;
		logic [16:0]                       reps;
		logic                              pre;
		logic                              chk;
		tbsfr_pkg::status_t                st;
		logic [tbsfr_pkg::BYTE_W-1:0]      byt;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		'{ACT_UNUSED, 32'hFFFFFFFF, 17'd1, 1'b0, 1'b0, tbsfr_pkg::STAT_GOOD,    8'h00},
		'{tbsfr_pkg::ACT_TICK,   32'h00000000, 17'd3, 1'b0, 1'b0, tbsfr_pkg::STAT_GOOD, 8'h00},
		'{tbsfr_pkg::ACT_WINDOW, 32'h00000000, 17'd1, 1'b0, 1'b0, tbsfr_pkg::STAT_GOOD, 8'h00},
		'{tbsfr_pkg::ACT_TICK,   32'h00000000, 17'd2, 1'b0, 1'b0, tbsfr_pkg::STAT_GOOD, 8'h00},
		'{tbsfr_pkg::ACT_WINDOW, 32'hFFFFFFFF, 17'd1, 1'b1, 1'b0, tbsfr_pkg::STAT_GOOD, 8'h00},
		'{tbsfr_pkg::ACT_WINDOW, 32'h00000000, 17'd7, 1'b0, 1'b0, tbsfr_pkg::STAT_GOOD, 8'h00},
		'{tbsfr_pkg::ACT_WINDOW, 32'h00000000, 17'd1, 1'b0, 1'b1,
			tbsfr_pkg::STAT_PARITY, 8'h80},
		'{tbsfr_pkg::ACT_WINDOW, 32'h00000000, 17'd1, 1'b0, 1'b0, tbsfr_pkg::STAT_GOOD, 8'h00},
		'{tbsfr_pkg::ACT_WINDOW, 32'hFFFFFFFF, 17'd8, 1'b1, 1'b0, tbsfr_pkg::STAT_GOOD, 8'h00},
		'{tbsfr_pkg::ACT_WINDOW, 32'h00000000, 17'd1, 1'b0, 1'b1, tbsfr_pkg::STAT_GOOD, 8'hFF},
		'{tbsfr_pkg::ACT_WINDOW, 32'h00000000, 17'd1, 1'b0, 1'b0, tbsfr_pkg::STAT_GOOD, 8'h00},
		'{tbsfr_pkg::ACT_WINDOW, 32'h00000000, 17'd8, 1'b1, 1'b0, tbsfr_pkg::STAT_GOOD, 8'h00},
		'{tbsfr_pkg::ACT_WINDOW, 32'h00000001, 17'd1, 1'b1, 1'b1,
			tbsfr_pkg::STAT_PARITY, 8'h00},
		'{tbsfr_pkg::ACT_TICK,   32'h00000000, 17'd2, 1'b0, 1'b0, tbsfr_pkg::STAT_GOOD, 8'h00},
		'{tbsfr_pkg::ACT_WINDOW, 32'h00000000, 17'd1, 1'b0, 1'b1,
			tbsfr_pkg::STAT_TIMEOUT, 8'h00},
		'{tbsfr_pkg::ACT_TICK,   32'h00000000, 17'd1, 1'b0, 1'b0, tbsfr_pkg::STAT_GOOD, 8'h00},
		'{tbsfr_pkg::ACT_WINDOW, 32'h00000000, 17'd1, 1'b0, 1'b0, tbsfr_pkg::STAT_GOOD, 8'h00},
		'{tbsfr_pkg::ACT_SAMPLE, 32'hFFFFFFFF, 17'd3, 1'b0, 1'b0, tbsfr_pkg::STAT_GOOD, 8'h00},
		'{tbsfr_pkg::ACT_WINDOW, 32'h00000000, 17'd1, 1'b0, 1'b0, tbsfr_pkg::STAT_GOOD, 8'h00},
		'{tbsfr_pkg::ACT_WINDOW, 32'hFFFFFFFE, 17'd8, 1'b1, 1'b0, tbsfr_pkg::STAT_GOOD, 8'h00},
		'{tbsfr_pkg::ACT_WINDOW, 32'h00000000, 17'd1, 1'b0, 1'b1,
			tbsfr_pkg::STAT_PARITY, 8'h00}
	};

	logic                                  clk       = 1'b0;
	logic                                  arst_n    = 1'b0;
	logic                                  s_tvalid  = 1'b0;
	logic                                  s_tready;
	logic [tbsfr_pkg::LAT_W-1:0]           s_tdata   = '0;
	logic [1:0]                            s_tuser   = '0;
	logic                                  m_tvalid;
	logic                                  m_tready  = 1'b0;
	logic [tbsfr_pkg::BYTE_W-1:0]          m_tdata;
	logic [1:0]                            m_tuser;
	logic                                  cfg_valid = 1'b0;
	logic                                  cfg_ready;
	logic [tbsfr_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [tbsfr_pkg::CFG_DATA_W-1:0]      cfg_data  = '0;

	frame_res_t             pending_q[$];
	int                     errors     = 0;
	int                     rx_count   = 0;
	int                     items_sent = 0;
	int                     burst_left = 0;
	int                     idle_cycles = 0;
	bit                     fixed_on   = 1'b0;
	frame_res_t             fixed_res;

	logic [tbsfr_pkg::THR_W-1:0]           thr_cfg   = '0;
	logic [tbsfr_pkg::TICK_W-1:0]          tmo_cfg   = '0;
	logic [tbsfr_pkg::DELIM_W-1:0]         delim_cfg = tbsfr_pkg::DELIM_RESET;
	logic                                  odd_cfg   = 1'b0;

	logic [tbsfr_pkg::SUM_W-1:0]           lat_sum   = '0;
	logic [tbsfr_pkg::COUNT_BITS_DEF-1:0]  lat_cnt   = '0;
	logic [tbsfr_pkg::DELIM_W-1:0]         hunt_reg  = '0;
	logic                                  rx_on     = 1'b0;
	logic [3:0]                            bit_pos   = '0;
	logic [tbsfr_pkg::BYTE_W-1:0]          byte_reg  = '0;
	logic [tbsfr_pkg::TICK_W-1:0]          tick_cnt  = '0;

	timing_bit_slicer_frame_receiver_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic slice_step(input logic [1:0] act, input logic [tbsfr_pkg::LAT_W-1:0] lat,
			output bit got, output frame_res_t res);
		logic [tbsfr_pkg::SUM_W:0] wide;
		logic [63:0]               need;
		logic                      b;
		got = 1'b0;
		res = '0;
		case (act)
			tbsfr_pkg::ACT_SAMPLE: begin
				wide = {1'b0, lat_sum} + tbsfr_pkg::SUM_W'(lat);
				lat_sum = wide[tbsfr_pkg::SUM_W] ? '1 : wide[tbsfr_pkg::SUM_W-1:0];
				if (lat_cnt != '1)
					lat_cnt = lat_cnt + 1'b1;
			end
			tbsfr_pkg::ACT_TICK: begin
				if (!rx_on && tick_cnt != '1)
					tick_cnt = tick_cnt + 1'b1;
			end
			tbsfr_pkg::ACT_WINDOW: begin
				need = (64'(thr_cfg) + 64'd1) * 64'(lat_cnt);
				b = (lat_cnt != '0) && (64'(lat_sum) >= need);
				lat_sum = '0;
				lat_cnt = '0;
				if (!rx_on) begin
					hunt_reg = {hunt_reg[tbsfr_pkg::DELIM_W-2:0], b};
					if (hunt_reg == delim_cfg) begin
						rx_on = 1'b1;
						bit_pos = '0;
						byte_reg = '0;
						tick_cnt = '0;
					end else if (tmo_cfg != '0 && tick_cnt > tmo_cfg) begin
						got = 1'b1;
						res.status = tbsfr_pkg::STAT_TIMEOUT;
						res.data = '0;
						hunt_reg = '0;
						tick_cnt = '0;
					end
				end else if (bit_pos < tbsfr_pkg::DATA_BITS_DEF) begin
					byte_reg = {byte_reg[tbsfr_pkg::BYTE_W-2:0], b};
					bit_pos = bit_pos + 1'b1;
				end else begin
					got = 1'b1;
					res.status = ((^byte_reg ^ b) == odd_cfg) ? tbsfr_pkg::STAT_GOOD
						: tbsfr_pkg::STAT_PARITY;
					res.data = byte_reg;
					rx_on = 1'b0;
					hunt_reg = '0;
					tick_cnt = '0;
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input logic [1:0] act, input logic [tbsfr_pkg::LAT_W-1:0] lat);
		int         gap;
		bit         got;
		frame_res_t res;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 20);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= lat;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		if (act != ACT_UNUSED)
			items_sent++;
		slice_step(act, lat, got, res);
		if (got)
			pending_q.push_back(fixed_on ? fixed_res : res);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input tbsfr_pkg::reg_index_t idx,
			input logic [tbsfr_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			tbsfr_pkg::REG_THRESHOLD: thr_cfg = val;
			tbsfr_pkg::REG_TIMEOUT:   tmo_cfg = val;
			tbsfr_pkg::REG_DELIMITER: delim_cfg = val[tbsfr_pkg::DELIM_W-1:0];
			tbsfr_pkg::REG_PARITY:    odd_cfg = val[0];
			default: ;
		endcase
	endtask

	task automatic reconfigure(input logic [tbsfr_pkg::THR_W-1:0] thr,
			input logic [tbsfr_pkg::TICK_W-1:0] tmo,
			input logic [tbsfr_pkg::DELIM_W-1:0] delim, input logic odd);
		drain();
		write_reg(tbsfr_pkg::REG_THRESHOLD, thr);
		write_reg(tbsfr_pkg::REG_TIMEOUT, tmo);
		write_reg(tbsfr_pkg::REG_DELIMITER, tbsfr_pkg::CFG_DATA_W'(delim));
		write_reg(tbsfr_pkg::REG_PARITY, tbsfr_pkg::CFG_DATA_W'(odd));
		cfg_valid <= 1'b0;
	endtask

	task automatic send_bit(input bit b);
		int                          n;
		logic [tbsfr_pkg::LAT_W-1:0] lat;
		bit                          one;
		one = b && (thr_cfg != '1);
		n = one ? $urandom_range(1, 3) : $urandom_range(0, 3);
		repeat (n) begin
			if (one)
				lat = ($urandom_range(0, 3) == 0) ? thr_cfg + 1'b1
					: $urandom_range(32'hFFFFFFFF, thr_cfg + 1'b1);
			else
				lat = ($urandom_range(0, 3) == 0) ? thr_cfg : $urandom_range(thr_cfg, 0);
			send_item(tbsfr_pkg::ACT_SAMPLE, lat);
		end
		send_item(tbsfr_pkg::ACT_WINDOW, $urandom);
	endtask

	task automatic run_episode();
		int                           kind;
		int                           n;
		logic [tbsfr_pkg::BYTE_W-1:0] d;
		logic [tbsfr_pkg::LAT_W-1:0]  lat;
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			d = tbsfr_pkg::BYTE_W'($urandom);
			for (int i = tbsfr_pkg::DELIM_W - 1; i >= 0; i--) begin
				if ($urandom_range(0, 7) == 0)
					send_item(tbsfr_pkg::ACT_TICK, $urandom);
				send_bit(delim_cfg[i]);
			end
			for (int i = tbsfr_pkg::BYTE_W - 1; i >= 0; i--) begin
				if ($urandom_range(0, 15) == 0)
					send_item(tbsfr_pkg::ACT_TICK, $urandom);
				send_bit(d[i]);
			end
			send_bit(^d ^ odd_cfg ^ ($urandom_range(0, 3) == 0));
		end else if (kind < 85) begin
			n = $urandom_range(0, (tmo_cfg < 40) ? int'(tmo_cfg) + 3 : 40);
			repeat (n) send_item(tbsfr_pkg::ACT_TICK, $urandom);
			repeat ($urandom_range(1, 3)) send_bit(1'($urandom_range(0, 1)));
		end else begin
			repeat ($urandom_range(1, 10)) begin
				case ($urandom_range(0, 4))
					0: lat = '0;
					1: lat = '1;
					2: lat = thr_cfg;
					3: lat = thr_cfg + 1'b1;
					default: lat = $urandom;
				endcase
				send_item(2'($urandom_range(0, 3)), lat);
			end
		end
	endtask

	// receiver: changing stall pattern, one long hold-off to back the block up
	initial begin
		int  cyc;
		int  mode;
		bit  held;
		cyc = 0;
		mode = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (!held && rx_count >= HOLD_AFTER) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1'b1;
			end else begin
				if (cyc % 64 == 0)
					mode = $urandom_range(0, 3);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= (cyc % 5) != 0;
					2: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= (cyc % 4) == 0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		frame_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			rx_count++;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result, status %0d data 0x%02h",
					$time, m_tuser, m_tdata);
				errors++;
			end else begin
				want = pending_q.pop_front();
				if (m_tuser != want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status, m_tuser);
					errors++;
				end
				if (m_tdata != want.data) begin
					$display("%0t: data_byte expected 0x%02h got 0x%02h",
						$time, want.data, m_tdata);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timing_bit_slicer_frame_receiver_core_tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int start_items;
		int k;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		reconfigure(32'd0, 32'd0, 8'h00, 1'b0);
		for (int i = 0; i < DIR_N; i++) begin
			if (i == DIR_SPLIT)
				reconfigure(32'hFFFFFFFE, 32'd1, 8'h01, 1'b1);
			for (int r = 0; r < int'(DIR_ROWS[i].reps); r++) begin
				if (DIR_ROWS[i].pre)
					send_item(tbsfr_pkg::ACT_SAMPLE, DIR_ROWS[i].lat);
				fixed_on = DIR_ROWS[i].chk && (r == int'(DIR_ROWS[i].reps) - 1);
				fixed_res.status = DIR_ROWS[i].st;
				fixed_res.data = DIR_ROWS[i].byt;
				send_item(DIR_ROWS[i].act, DIR_ROWS[i].lat);
				fixed_on = 1'b0;
			end
		end

		start_items = items_sent;
		k = 0;
		while (items_sent - start_items < ITEM_TARGET) begin
			case (k % 6)
				0: reconfigure(32'd0, 32'd0, 8'h00, 1'b1);
				1: reconfigure(32'hFFFFFFFF, 32'd5, 8'h00, 1'b0);
				2: reconfigure($urandom_range(0, 1000), 32'hFFFFFFFF, 8'hFF, 1'b1);
				3: reconfigure($urandom, $urandom_range(3, 40), tbsfr_pkg::DELIM_W'($urandom),
					1'($urandom_range(0, 1)));
				4: reconfigure($urandom_range(0, 50), 32'd1, tbsfr_pkg::DELIM_W'($urandom), 1'b0);
				default: reconfigure($urandom, 32'd0, tbsfr_pkg::DELIM_RESET,
					1'($urandom_range(0, 1)));
			endcase
			k++;
			begin
				int phase_start;
				phase_start = items_sent;
				while (items_sent - phase_start < PHASE_ITEMS) run_episode();
			end
		end

		drain();
		if (errors == 0)
			$display("timing_bit_slicer_frame_receiver_core_tb: done, clean");
		else
			$display("timing_bit_slicer_frame_receiver_core_tb: done, errors");
		$finish;
	end

endmodule
